// ===== sv/ssba_pkg.sv =====
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared types and constants of the swap slot bitmap allocator.
// ----------------------------------------------------------------------------
package ssba_pkg;

  localparam int MAX_SLOTS        = 1024;
  localparam int SECTORS_PER_PAGE = 8;
  localparam int SECTOR_BYTES     = 512;

  localparam int SLOT_W   = 10;
  localparam int SECTOR_W = 13;
  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 11;

  localparam int ROW_BITS = 32;
  localparam int ROWS     = MAX_SLOTS / ROW_BITS;
  localparam int ROW_AW   = $clog2(ROWS);
  localparam int BIT_AW   = $clog2(ROW_BITS);
  localparam int BEAT_W   = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(1024);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    REQ_SWAP_OUT = 1'b0,
    REQ_SWAP_IN  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_CHECK,
    CS_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic check;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic load_ok;
    logic last_beat;
  } dp_status_t;

endpackage

// ===== sv/ssba_if.sv =====
// ----------------------------------------------------------------------------
// ssba_req_if / ssba_rsp_if
// Valid/ready channels for swap requests and sector transfer results.
// ----------------------------------------------------------------------------
interface ssba_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [9:0]  slot_index;
  logic [31:0] page_address;

  modport source (output valid, req_type, slot_index, page_address, input ready);
  modport sink   (input valid, req_type, slot_index, page_address, output ready);
endinterface

interface ssba_rsp_if;
  logic        valid;
  logic        ready;
  logic [9:0]  slot;
  logic [12:0] sector_number;
  logic [31:0] buffer_address;
  logic        is_write;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, slot, sector_number, buffer_address, is_write, status, last,
                  input ready);
  modport sink   (input valid, slot, sector_number, buffer_address, is_write, status, last,
                  output ready);
endinterface

// ===== sv/swap_slot_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator_core
// First-fit swap slot allocator with per-sector transfer results.
// ----------------------------------------------------------------------------
// Requests come in on req (valid/ready); results leave on rsp (valid/ready).
// A swap out takes the lowest free slot below min(slot_count, 1024) and gives
// eight write results, one per sector; a swap in of a used slot frees it and
// gives eight read results. Errors give one result with last set.
// One request is handled at a time: accept, bitmap row read, check/update,
// then one result per cycle into the output register while the receiver
// keeps up. The bitmap is a 32x32 RAM with a registered row read, so the
// row is read in a state of its own between accept and check.
// req.ready rises once the last result is in the output register, so the
// next request is taken while that result still waits. A stalled receiver
// holds the output register and the block waits.
// Reset clears the row valid and row full flags at once, so the whole bitmap
// reads as free with no clearing pass; slot_count resets to 1024. Writes to
// slot_count go through cfg_wr_en/cfg_wr_data and belong in idle time only.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_core
  import ssba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  ssba_req_if.sink         req,
  ssba_rsp_if.source       rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       ctrl_ready;

  ssba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ctrl_ready),
    .status    (status),
    .cmd       (cmd)
  );

  assign req.ready = ctrl_ready;

  ssba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .req         (req),
    .rsp         (rsp)
  );

endmodule

// ===== sv/ssba_ram.sv =====
// ----------------------------------------------------------------------------
// ssba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ssba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ssba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssba_ctrl
// Request sequencer: accept, bitmap row read, check/update, sector emit.
// ----------------------------------------------------------------------------
module ssba_ctrl
  import ssba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (req_valid) state_next = CS_READ;
      end
      CS_READ:  state_next = CS_CHECK;
      CS_CHECK: state_next = CS_EMIT;
      CS_EMIT: begin
        if (status.load_ok && status.last_beat) state_next = CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      CS_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      CS_READ: ;
      CS_CHECK: cmd.check = 1'b1;
      CS_EMIT:  cmd.load  = status.load_ok;
      default: ;
    endcase
  end

  a_load_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == CS_EMIT))
    else $error("result load outside emit");

  a_check_follows_read: assert property (@(posedge clk) disable iff (rst)
    cmd.check |-> $past(state == CS_READ))
    else $error("check without row read");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != CS_IDLE) |-> !cmd.accept)
    else $error("request taken while busy");

endmodule

// ===== sv/ssba_dp.sv =====
// ----------------------------------------------------------------------------
// ssba_dp
// Bitmap store, first-fit search, request check and sector result stepping.
// ----------------------------------------------------------------------------
module ssba_dp
  import ssba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  ctrl_cmd_t        cmd,
  output dp_status_t       status,
  ssba_req_if.sink         req,
  ssba_rsp_if.source       rsp
);

  logic [CNT_W-1:0]    slot_count;
  logic [CNT_W-1:0]    active_n;

  logic                req_type_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [ADDR_W-1:0]   base_q;
  logic [ROW_AW-1:0]   row_q;
  logic                any_free_q;

  logic [ROWS-1:0]     row_valid;
  logic [ROWS-1:0]     row_full;
  logic [ROW_AW-1:0]   free_row;

  logic [ROW_BITS-1:0] ram_rdata;
  logic [ROW_BITS-1:0] row_data;
  logic [BIT_AW-1:0]   zero_bit;
  logic [SLOT_W-1:0]   cand_slot;
  logic [BIT_AW-1:0]   idx_bit;

  logic                ok_c;
  status_t             status_c;
  logic [SLOT_W-1:0]   slot_c;
  logic [ROW_BITS-1:0] wdata_c;
  logic                ram_we;

  status_t             res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_wr;
  logic [SECTOR_W-1:0] sector_cur;
  logic [ADDR_W-1:0]   addr_cur;
  logic [BEAT_W-1:0]   beat;

  logic                out_valid;
  logic [SLOT_W-1:0]   out_slot;
  logic [SECTOR_W-1:0] out_sector;
  logic [ADDR_W-1:0]   out_addr;
  logic                out_wr;
  status_t             out_status;
  logic                out_last;
  logic                beat_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RST;
    end else if (cfg_wr_en) begin
      slot_count <= cfg_wr_data;
    end
  end

  assign active_n = (slot_count > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count;

  // lowest row with a free slot
  always_comb begin
    free_row = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!row_full[i]) free_row = ROW_AW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_q <= req.req_type;
      idx_q      <= req.slot_index;
      base_q     <= req.page_address;
      any_free_q <= ~&row_full;
      row_q      <= (req.req_type == REQ_SWAP_IN) ? req.slot_index[SLOT_W-1 -: ROW_AW]
                                                  : free_row;
    end
  end

  ssba_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(ROWS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_q),
    .wdata (wdata_c),
    .raddr (row_q),
    .rdata (ram_rdata)
  );

  assign row_data = row_valid[row_q] ? ram_rdata : '0;

  always_comb begin
    zero_bit = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!row_data[i]) zero_bit = BIT_AW'(i);
    end
  end

  assign cand_slot = {row_q, zero_bit};
  assign idx_bit   = idx_q[BIT_AW-1:0];

  always_comb begin
    ok_c     = 1'b0;
    status_c = ST_OK;
    slot_c   = idx_q;
    wdata_c  = row_data;
    if (req_type_q == REQ_SWAP_OUT) begin
      if (any_free_q && ({1'b0, cand_slot} < active_n)) begin
        ok_c              = 1'b1;
        slot_c            = cand_slot;
        wdata_c[zero_bit] = 1'b1;
      end else begin
        status_c = ST_FULL;
        slot_c   = '0;
      end
    end else if ({1'b0, idx_q} >= active_n) begin
      status_c = ST_RANGE;
    end else if (!row_data[idx_bit]) begin
      status_c = ST_EMPTY;
    end else begin
      ok_c             = 1'b1;
      wdata_c[idx_bit] = 1'b0;
    end
  end

  assign ram_we = cmd.check && ok_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_full  <= '0;
    end else if (ram_we) begin
      row_valid[row_q] <= 1'b1;
      row_full[row_q]  <= &wdata_c;
    end
  end

  assign beat_last = (res_status != ST_OK) || (beat == BEAT_W'(SECTORS_PER_PAGE - 1));

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res_status <= status_c;
      res_slot   <= slot_c;
      res_wr     <= (req_type_q == REQ_SWAP_OUT);
      sector_cur <= SECTOR_W'(SECTOR_W'(slot_c) * SECTOR_W'(SECTORS_PER_PAGE));
      addr_cur   <= base_q;
      beat       <= '0;
    end else if (cmd.load) begin
      sector_cur <= sector_cur + SECTOR_W'(1);
      addr_cur   <= addr_cur + ADDR_W'(SECTOR_BYTES);
      beat       <= beat + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_slot   <= res_slot;
      out_status <= res_status;
      out_last   <= beat_last;
      if (res_status == ST_OK) begin
        out_sector <= sector_cur;
        out_addr   <= addr_cur;
        out_wr     <= res_wr;
      end else begin
        out_sector <= '0;
        out_addr   <= '0;
        out_wr     <= 1'b0;
      end
    end
  end

  assign status.load_ok   = !out_valid || rsp.ready;
  assign status.last_beat = beat_last;

  assign rsp.valid          = out_valid;
  assign rsp.slot           = out_slot;
  assign rsp.sector_number  = out_sector;
  assign rsp.buffer_address = out_addr;
  assign rsp.is_write       = out_wr;
  assign rsp.status         = out_status;
  assign rsp.last           = out_last;

  a_full_implies_valid: assert property (@(posedge clk) disable iff (rst)
    (row_full & ~row_valid) == '0)
    else $error("full row never written");

  a_ok_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && (res_status == ST_OK)) |-> ({1'b0, res_slot} < active_n))
    else $error("transfer for slot beyond active count");

  a_error_is_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> out_last)
    else $error("error result not marked last");

endmodule

// ===== verif/swap_slot_bitmap_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator_core_tb
// Self-checking bench for the first-fit swap slot allocator.
// ----------------------------------------------------------------------------
// A driver feeds swap requests from a queue and a monitor takes the sector
// results. At each accepted request an in-bench bitmap predicts the results,
// and each result is checked field by field against the oldest prediction.
// Directed requests cover range, empty and full errors and address wrap.
// Random phases then run under several slot counts with random idling.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_core_tb;
  import ssba_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_HOLD      = 150;
  localparam int LONG_HOLD_AT   = 50;

  typedef struct packed {
    req_kind_t          kind;
    logic [SLOT_W-1:0]  idx;
    logic [ADDR_W-1:0]  page;
  } swap_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector;
    logic [ADDR_W-1:0]   addr;
    logic                wr;
    status_t             status;
    logic                last;
  } xfer_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  ssba_req_if req_ch ();
  ssba_rsp_if rsp_ch ();

  swap_slot_bitmap_allocator_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  bit               slot_busy [MAX_SLOTS];
  logic [CNT_W-1:0] slot_limit = SLOT_COUNT_RST;

  swap_req_t pending_reqs [$];
  xfer_t     expected_xfers [$];
  swap_req_t on_bus;
  xfer_t     want;
  string     diffs;

  int  reqs_issued    = 0;
  int  reqs_accepted  = 0;
  int  results_seen   = 0;
  int  mismatches     = 0;
  int  idle_pct       = 0;
  int  gap_left       = 0;
  int  hold_left      = 0;
  bit  long_hold_done = 0;
  int  quiet_cycles   = 0;

  always #6 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic void queue_page(int unsigned s, logic [ADDR_W-1:0] page, logic wr);
    int j;
    for (j = 0; j < SECTORS_PER_PAGE; j++) begin
      expected_xfers.push_back('{slot: SLOT_W'(s),
                                 sector: SECTOR_W'(s * SECTORS_PER_PAGE + j),
                                 addr: ADDR_W'(page + SECTOR_BYTES * j),
                                 wr: wr, status: ST_OK,
                                 last: (j == SECTORS_PER_PAGE - 1)});
    end
  endfunction

  function automatic void predict_transfers(swap_req_t r);
    int unsigned lim;
    int unsigned s;
    lim = (slot_limit > MAX_SLOTS) ? MAX_SLOTS : slot_limit;
    if (r.kind == REQ_SWAP_OUT) begin
      s = 0;
      while (s < lim && slot_busy[s]) s++;
      if (s >= lim) begin
        expected_xfers.push_back('{slot: '0, sector: '0, addr: '0, wr: 1'b0,
                                   status: ST_FULL, last: 1'b1});
      end else begin
        slot_busy[s] = 1'b1;
        queue_page(s, r.page, 1'b1);
      end
    end else if (r.idx >= lim) begin
      expected_xfers.push_back('{slot: r.idx, sector: '0, addr: '0, wr: 1'b0,
                                 status: ST_RANGE, last: 1'b1});
    end else if (!slot_busy[r.idx]) begin
      expected_xfers.push_back('{slot: r.idx, sector: '0, addr: '0, wr: 1'b0,
                                 status: ST_EMPTY, last: 1'b1});
    end else begin
      slot_busy[r.idx] = 1'b0;
      queue_page(r.idx, r.page, 1'b0);
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  // ---------------- request driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_transfers(on_bus);
        reqs_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          on_bus = pending_reqs.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.req_type     <= on_bus.kind;
          req_ch.slot_index   <= on_bus.idx;
          req_ch.page_address <= on_bus.page;
          if ($urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 3);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_xfers.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want  = expected_xfers.pop_front();
          diffs = "";
          if (rsp_ch.slot !== want.slot) diffs = {diffs, " slot"};
          if (rsp_ch.sector_number !== want.sector) diffs = {diffs, " sector_number"};
          if (rsp_ch.buffer_address !== want.addr) diffs = {diffs, " buffer_address"};
          if (rsp_ch.is_write !== want.wr) diffs = {diffs, " is_write"};
          if (rsp_ch.status !== want.status) diffs = {diffs, " status"};
          if (rsp_ch.last !== want.last) diffs = {diffs, " last"};
          if (diffs != "")
            report_mismatch($sformatf(
              "bad%s: got %0d/%0d/%h/%b/%0d/%b want %0d/%0d/%h/%b/%0d/%b", diffs,
              rsp_ch.slot, rsp_ch.sector_number, rsp_ch.buffer_address, rsp_ch.is_write,
              rsp_ch.status, rsp_ch.last, want.slot, want.sector, want.addr, want.wr,
              want.status, want.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!long_hold_done && reqs_accepted >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        hold_left = $urandom_range(0, 2);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[swap_slot_bitmap_allocator_core] ERROR");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic send(req_kind_t kind, int unsigned idx, logic [ADDR_W-1:0] page);
    swap_req_t r;
    r.kind = kind;
    r.idx  = SLOT_W'(idx);
    r.page = page;
    pending_reqs.push_back(r);
    reqs_issued++;
  endtask

  task automatic wait_drained();
    while (reqs_accepted != reqs_issued || expected_xfers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    slot_limit = value;
  endtask

  task automatic run_phase(logic [CNT_W-1:0] cnt, int n, int unsigned span, int pct);
    int k;
    req_kind_t kind;
    int unsigned idx;
    logic [ADDR_W-1:0] page;
    write_slot_count(cnt);
    idle_pct = pct;
    for (k = 0; k < n; k++) begin
      kind = ($urandom_range(0, 99) < 55) ? REQ_SWAP_OUT : REQ_SWAP_IN;
      idx  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_SLOTS - 1)
                                         : $urandom_range(0, span);
      page = ($urandom_range(0, 4) == 0) ? $urandom : ($urandom & 32'hFFFF_F000);
      send(kind, idx, page);
    end
    wait_drained();
  endtask

  initial begin
    int k;
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type     = REQ_SWAP_OUT;
    req_ch.slot_index   = '0;
    req_ch.page_address = '0;
    rsp_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    send(REQ_SWAP_OUT, 0, 32'h0000_0000);
    send(REQ_SWAP_OUT, 0, 32'hFFFF_FFFF);
    send(REQ_SWAP_IN, 0, 32'h0000_1000);
    send(REQ_SWAP_IN, 0, 32'h0000_2000);
    send(REQ_SWAP_IN, 1023, 32'h0000_3000);
    send(REQ_SWAP_OUT, 1023, 32'hFFFF_F000);
    for (k = 0; k < 8; k++) send(REQ_SWAP_OUT, $urandom_range(0, 1023), $urandom & 32'hFFFF_F000);
    wait_drained();

    // bits above the new count stay set but are out of range
    write_slot_count(11'd4);
    send(REQ_SWAP_IN, 7, 32'h1234_5000);
    send(REQ_SWAP_OUT, 0, 32'h0001_0000);
    send(REQ_SWAP_IN, 3, 32'h0002_0000);
    send(REQ_SWAP_OUT, 0, 32'h0003_0000);
    send(REQ_SWAP_IN, 4, 32'h0004_0000);
    wait_drained();

    write_slot_count(11'd0);
    send(REQ_SWAP_OUT, 0, 32'h0005_0000);
    send(REQ_SWAP_IN, 0, 32'h0006_0000);
    send(REQ_SWAP_IN, 1023, 32'h0007_0000);
    wait_drained();

    // saturates at the maximum slot count
    write_slot_count(11'd2047);
    send(REQ_SWAP_IN, 7, 32'h8000_0000);
    send(REQ_SWAP_IN, 1023, 32'h0008_0000);
    send(REQ_SWAP_IN, 9, 32'hFFFF_FFFF);
    wait_drained();

    run_phase(11'd24, 60, 26, 20);
    run_phase(11'd1024, 50, 60, 40);
    run_phase(11'd70, 70, 72, 10);
    run_phase(11'd2047, 40, 80, 0);
    run_phase(11'd1, 30, 3, 25);
    run_phase(CNT_W'($urandom_range(2, 200)), 50, 202, 15);
    run_phase(11'd1024, 40, 100, 0);

    if (mismatches == 0 && expected_xfers.size() == 0) begin
      $display("[swap_slot_bitmap_allocator_core] OK");
    end else begin
      $display("[swap_slot_bitmap_allocator_core] ERROR");
    end
    $finish;
  end

endmodule
